// ===== src/fla_pkg.sv =====
// shared codes and control types for the free list entry allocator
`timescale 1ns / 1ps
package fla_pkg;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_QUERY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_ALREADY = 2'd3;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

endpackage

// ===== src/fla_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module fla_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/fla_ctrl.sv =====
// request sequencer: accepts a word, waits for the store read, commits the result
`timescale 1ns / 1ps
module fla_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output fla_pkg::cmd_t cmd
);

  import fla_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_commit_in_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> state == S_EXEC)
    else $error("commit outside exec state");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> !cmd.load)
    else $error("word accepted while busy");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

endmodule

// ===== src/fla_dp.sv =====
// datapath: head, free count, fill mark, link and mark store, result registers
`timescale 1ns / 1ps
module fla_dp #(
  parameter int POOL_ENTRIES = 4096,
  parameter int IW           = 13,
  parameter int AW           = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  fla_pkg::cmd_t cmd,
  input  logic [1:0]    func,
  input  logic [IW-1:0] entry,
  output logic [1:0]    status,
  output logic [IW-1:0] granted_entry,
  output logic          is_free,
  output logic [IW-1:0] free_count
);

  import fla_pkg::*;

  localparam logic [IW-1:0] NONE = IW'(POOL_ENTRIES);

  logic [1:0]    req_func;
  logic [IW-1:0] req_entry;
  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [IW-1:0] total;
  logic [IW-1:0] total_next;
  logic [IW-1:0] fill;
  logic [IW-1:0] fill_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [IW:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [IW:0]   ram_rdata;

  logic          rd_mark;
  logic [IW-1:0] rd_link;
  logic          ent_mark;
  logic          head_fresh;
  logic [IW-1:0] head_link;

  logic [1:0]    status_next;
  logic [IW-1:0] granted_next;
  logic          is_free_next;

  // entries at or above fill were never handed out: link i+1, marked free
  assign ram_raddr = (func == FN_ALLOC) ? head[AW-1:0] : entry[AW-1:0];

  fla_ram #(
    .WIDTH (IW + 1),
    .DEPTH (POOL_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.load),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_mark    = ram_rdata[IW];
  assign rd_link    = ram_rdata[IW-1:0];
  assign ent_mark   = (req_entry >= fill) ? 1'b1 : rd_mark;
  assign head_fresh = (head >= fill);
  assign head_link  = head_fresh ? (head + IW'(1)) : rd_link;

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = head[AW-1:0];
    ram_wdata    = {1'b0, head_link};
    head_next    = head;
    total_next   = total;
    fill_next    = fill;
    status_next  = ST_OK;
    granted_next = NONE;
    is_free_next = 1'b0;
    case (req_func)
      FN_ALLOC: begin
        if (head >= NONE || total == '0) begin
          status_next = ST_EMPTY;
        end else begin
          ram_we       = cmd.commit;
          head_next    = head_link;
          total_next   = total - IW'(1);
          granted_next = head;
          if (head_fresh) fill_next = head + IW'(1);
        end
      end
      FN_FREE: begin
        if (req_entry >= NONE) begin
          status_next = ST_RANGE;
        end else if (ent_mark) begin
          status_next = ST_ALREADY;
        end else begin
          ram_we     = cmd.commit;
          ram_waddr  = req_entry[AW-1:0];
          ram_wdata  = {1'b1, head};
          head_next  = req_entry;
          total_next = total + IW'(1);
        end
      end
      FN_QUERY: begin
        if (req_entry >= NONE) begin
          status_next = ST_RANGE;
        end else begin
          is_free_next = ent_mark;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      total <= NONE;
      fill  <= '0;
    end else if (cmd.commit) begin
      head  <= head_next;
      total <= total_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func  <= func;
      req_entry <= entry;
    end
    if (cmd.commit) begin
      status        <= status_next;
      granted_entry <= granted_next;
      is_free       <= is_free_next;
      free_count    <= total_next;
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= NONE)
    else $error("free count above pool size");

  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    (head == NONE) == (total == '0))
    else $error("head and free count disagree on empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= NONE && (head < fill || head == fill || head == NONE))
    else $error("fill mark inconsistent with head");

endmodule

// ===== src/free_list_entry_allocator.sv =====
// top level of the linked free list entry allocator
// Hands out and takes back entries of a pool of POOL_ENTRIES through a linked
// free list kept in one ram word per entry (next link plus free mark). Every
// request (allocate, free, query) runs in order: the word is accepted and the
// ram is read at the head or the named entry, then, once the output register
// can take the result, the result is formed, the ram written and the result
// register loaded. A new word is taken once the previous one has been
// committed, even while its result still waits in the output register; a
// request whose result finds that register still full waits in the exec state
// until the result there is taken. A fill mark stands in for entries never
// handed out, so no clearing pass is needed after reset and the block takes
// requests at once.
`timescale 1ns / 1ps
module free_list_entry_allocator #(
  parameter int POOL_ENTRIES = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           func,
  input  logic [$clog2(POOL_ENTRIES + 1)-1:0]  entry,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           status,
  output logic [$clog2(POOL_ENTRIES + 1)-1:0]  granted_entry,
  output logic                                 is_free,
  output logic [$clog2(POOL_ENTRIES + 1)-1:0]  free_count
);

  import fla_pkg::*;

  localparam int IW = $clog2(POOL_ENTRIES + 1);
  localparam int AW = $clog2(POOL_ENTRIES);

  cmd_t cmd;

  fla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fla_dp #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .IW           (IW),
    .AW           (AW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .func          (func),
    .entry         (entry),
    .status        (status),
    .granted_entry (granted_entry),
    .is_free       (is_free),
    .free_count    (free_count)
  );

endmodule

// ===== dv/tb_free_list_entry_allocator.sv =====
// testbench for the linked free list entry allocator: directed, random, stall and release tests
`timescale 1ns / 1ps
module tb_free_list_entry_allocator;
  import fla_pkg::*;

  localparam int POOL = 4096;
  localparam int EW = $clog2(POOL + 1);
  localparam logic [EW-1:0] NO_ENTRY = EW'(POOL);
  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int IDLE_PCT = 34;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_WORDS = 1650;
  localparam int RELEASE_WORDS = 90;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct {
    logic [1:0]    status;
    logic [EW-1:0] granted;
    logic          is_free;
    logic [EW-1:0] count;
  } alloc_result_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  logic [1:0]    func;
  logic [EW-1:0] entry;
  logic          out_valid;
  logic          out_ready;
  logic [1:0]    status;
  logic [EW-1:0] granted_entry;
  logic          is_free;
  logic [EW-1:0] free_count;

  // shadow of the free list
  logic [EW-1:0] next_link [POOL];
  logic          on_list [POOL];
  logic [EW-1:0] list_head;
  logic [EW-1:0] free_left;
  logic [EW-1:0] held_entries [$];

  alloc_result_t pending_results [$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            steady = 0;
  bit            hold_request = 0;

  free_list_entry_allocator #(
    .POOL_ENTRIES(POOL)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .entry(entry),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .granted_entry(granted_entry),
    .is_free(is_free),
    .free_count(free_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic reset_free_list();
    for (int i = 0; i < POOL; i++) begin
      next_link[i] = EW'(i + 1);
      on_list[i] = 1'b1;
    end
    list_head = '0;
    free_left = EW'(POOL);
    held_entries.delete();
  endtask

  function automatic alloc_result_t apply_request(logic [1:0] f, logic [EW-1:0] e);
    alloc_result_t r;
    r.status = ST_OK;
    r.granted = NO_ENTRY;
    r.is_free = 1'b0;
    case (f)
      FN_ALLOC: begin
        if (list_head >= NO_ENTRY || free_left == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.granted = list_head;
          list_head = next_link[r.granted];
          on_list[r.granted] = 1'b0;
          free_left = free_left - 1'b1;
          held_entries.push_back(r.granted);
        end
      end
      FN_FREE: begin
        if (e >= NO_ENTRY) begin
          r.status = ST_RANGE;
        end else if (on_list[e]) begin
          r.status = ST_ALREADY;
        end else begin
          next_link[e] = list_head;
          list_head = e;
          on_list[e] = 1'b1;
          free_left = free_left + 1'b1;
          for (int i = 0; i < held_entries.size(); i++) begin
            if (held_entries[i] == e) begin
              held_entries.delete(i);
              break;
            end
          end
        end
      end
      FN_QUERY: begin
        if (e >= NO_ENTRY) r.status = ST_RANGE;
        else r.is_free = on_list[e];
      end
      default: ;
    endcase
    r.count = free_left;
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge with nothing driven in that step
  task automatic send_word(input logic [1:0] f, input logic [EW-1:0] e);
    int gap;
    in_valid <= 1'b1;
    func <= f;
    entry <= e;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(f, e));
    @(negedge clk);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40 || (pick < 72 && held_entries.size() == 0))
      send_word(FN_ALLOC, EW'($urandom_range(8191)));
    else if (pick < 72)
      send_word(FN_FREE, held_entries[$urandom_range(held_entries.size() - 1)]);
    else if (pick < 82)
      send_word(FN_QUERY, EW'($urandom_range(POOL - 1)));
    else if (pick < 87)
      send_word(FN_FREE, EW'($urandom_range(POOL - 1)));
    else if (pick < 93)
      send_word($urandom_range(1) ? FN_FREE : FN_QUERY, EW'($urandom_range(8191, POOL)));
    else
      send_word(FN_UNUSED, EW'($urandom_range(8191)));
  endtask

  task automatic test_directed();
    send_word(FN_QUERY, 13'd0);
    send_word(FN_QUERY, 13'd4095);
    send_word(FN_QUERY, 13'd4096);
    send_word(FN_QUERY, 13'd8191);
    send_word(FN_FREE, 13'd0);
    send_word(FN_FREE, 13'd4095);
    send_word(FN_FREE, 13'd4096);
    send_word(FN_FREE, 13'd8191);
    send_word(FN_UNUSED, 13'd8191);
    send_word(FN_UNUSED, 13'd0);
    send_word(FN_ALLOC, 13'd0);
    send_word(FN_ALLOC, 13'd8191);
    send_word(FN_ALLOC, 13'd0);
    send_word(FN_QUERY, 13'd1);
    send_word(FN_FREE, 13'd1);
    send_word(FN_QUERY, 13'd1);
    send_word(FN_FREE, 13'd1);
    send_word(FN_ALLOC, 13'd0);
    send_word(FN_FREE, 13'd0);
    send_word(FN_FREE, 13'd2);
    send_word(FN_ALLOC, 13'd0);
    send_word(FN_ALLOC, 13'd0);
  endtask

  task automatic test_random();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 700 && i < 1000);
      send_random_word();
    end
    steady = 0;
  endtask

  // receiver stops for a long stretch while words keep coming
  task automatic test_backpressure();
    hold_request = 1;
    repeat (30) send_random_word();
  endtask

  // query, bad free and unused code, then hand back held entries and reuse the last one freed
  task automatic test_release();
    send_word(FN_QUERY, EW'($urandom_range(POOL - 1)));
    send_word(FN_FREE, EW'($urandom_range(8191, POOL)));
    send_word(FN_UNUSED, EW'($urandom_range(8191)));
    for (int i = 0; i < RELEASE_WORDS && held_entries.size() > 0; i++) begin
      send_word(FN_FREE, held_entries[$urandom_range(held_entries.size() - 1)]);
    end
    send_word(FN_ALLOC, 13'd0);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, status %0d granted %0d", $time, status,
                 granted_entry);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d got %0d", $time, want.status, status);
        end
        if (granted_entry !== want.granted) begin
          mismatch_count++;
          $display("%0t: granted_entry expected %0d got %0d", $time, want.granted,
                   granted_entry);
        end
        if (is_free !== want.is_free) begin
          mismatch_count++;
          $display("%0t: is_free expected %0d got %0d", $time, want.is_free, is_free);
        end
        if (free_count !== want.count) begin
          mismatch_count++;
          $display("%0t: free_count expected %0d got %0d", $time, want.count, free_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = FN_ALLOC;
    entry = '0;
    reset_free_list();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_release();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
